[src/first_fit_page_allocator_macros.svh]
// Assertion macros for the first-fit page allocator.
// Depends on nothing; included by the top level.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

// Implication checked in the same cycle.
`define FFPA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define FFPA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ffpa_pkg.sv]
// Shared widths and codes for the first-fit page allocator.
// Depends on nothing; used by the top level and the divider.
`default_nettype none

package ffpa_pkg;

   localparam int REQ_W    = 13;
   localparam int ADDR_W   = 12;
   localparam int STATUS_W = 3;
   localparam int CMP_W    = 18;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_NOT_ALLOC = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

endpackage

`default_nettype wire

[src/first_fit_page_allocator.sv]
// A refused size is answered once the divider is done; each table walk (search,
// shift, merge) costs, for each entry, a read and a check or write through the
// free-table ports; one item is in work at a time.
// Flow: a new item is taken only in idle; the result register lets the next item enter.
// Reset: synchronous; after reset the free table is seeded with the whole page in
// the init state, during which no item is taken.
`default_nettype none

module first_fit_page_allocator #(
   parameter int PAGE_BYTES    = 4096,
   parameter int GRANULE_BYTES = 8,
   parameter int MAX_ENTRIES   = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_func,
   input  wire logic [ffpa_pkg::REQ_W-1:0]      req_size,
   input  wire logic [ffpa_pkg::ADDR_W-1:0]     req_free_addr,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [ffpa_pkg::ADDR_W-1:0]     rsp_grant_addr,
   output logic      [ffpa_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int PG  = PAGE_BYTES / GRANULE_BYTES;
   localparam int SW  = (PG > 1) ? $clog2(PG) : 1;
   localparam int LW  = $clog2(PG + 1);
   localparam int FW  = SW + LW;
   localparam int IW  = $clog2(MAX_ENTRIES);
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int RW  = $clog2(GRANULE_BYTES + 1);
   localparam int QW  = ffpa_pkg::REQ_W;
   localparam int XW  = ffpa_pkg::CMP_W;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_DIV, S_ARD, S_ACHK, S_AGRANT, S_RMRD, S_RMWR,
      S_URD, S_UCHK, S_PRD, S_PCHK, S_FDEC, S_INSRD, S_INSWR, S_INSPUT, S_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic                            func_ff, func_in;
   logic                            zero_ff, zero_in;
   logic [QW-1:0]                   g_ff, g_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [CW-1:0]                   pos_ff, pos_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [IW-1:0]                   slot_ff, slot_in;
   logic [SW-1:0]                   cur_start_ff, cur_start_in, prev_start_ff, prev_start_in;
   logic [LW-1:0]                   cur_len_ff, cur_len_in, prev_len_ff, prev_len_in;
   logic [LW-1:0]                   ulen_ff, ulen_in;
   logic [MAX_ENTRIES-1:0]          used_valid_ff, used_valid_in;
   ffpa_pkg::status_type            status_ff, status_in;
   logic [ffpa_pkg::ADDR_W-1:0]     grant_ff, grant_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ffpa_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [ffpa_pkg::ADDR_W-1:0]     rsp_grant_ff, rsp_grant_in;

   logic                            div_start;
   logic [QW-1:0]                   div_dividend;
   logic                            div_done;
   logic [QW-1:0]                   div_quo;
   logic [RW-1:0]                   div_rem;

   logic                            f_we;
   logic [IW-1:0]                   f_waddr, f_raddr;
   logic [FW-1:0]                   f_wdata, f_rdata;
   logic                            u_we;
   logic [IW-1:0]                   u_waddr, u_raddr;
   logic [FW-1:0]                   u_wdata, u_rdata;

   logic [SW-1:0]                   rd_start, ud_start;
   logic [LW-1:0]                   rd_len, ud_len;
   logic                            slot_found;
   logic [IW-1:0]                   slot_free;
   logic                            join_l, join_r;
   logic [SW-1:0]                   s_gran;

   ffpa_div #(.DIVISOR(GRANULE_BYTES)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   ffpa_ram #(.WIDTH(FW), .DEPTH(MAX_ENTRIES)) u_free_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   ffpa_ram #(.WIDTH(FW), .DEPTH(MAX_ENTRIES)) u_used_ram (
      .clock (clock),
      .we    (u_we),
      .waddr (u_waddr),
      .wdata (u_wdata),
      .raddr (u_raddr),
      .rdata (u_rdata)
   );

   assign rd_start = f_rdata[FW-1:LW];
   assign rd_len   = f_rdata[LW-1:0];
   assign ud_start = u_rdata[FW-1:LW];
   assign ud_len   = u_rdata[LW-1:0];
   assign s_gran   = SW'(g_ff);

   always_comb begin
      slot_found = 1'b0;
      slot_free  = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!used_valid_ff[i]) begin
            slot_found = 1'b1;
            slot_free  = IW'(i);
         end
      end
   end

   assign join_l = (idx_ff != '0) &&
                   (XW'(prev_start_ff) + XW'(prev_len_ff) == XW'(g_ff));
   assign join_r = (idx_ff != count_ff) &&
                   (XW'(g_ff) + XW'(ulen_ff) == XW'(cur_start_ff));

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      zero_in       = zero_ff;
      g_in          = g_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      ulen_in       = ulen_ff;
      used_valid_in = used_valid_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      div_start     = 1'b0;
      div_dividend  = req_size;
      f_we          = 1'b0;
      f_waddr       = idx_ff[IW-1:0];
      f_wdata       = f_rdata;
      f_raddr       = idx_ff[IW-1:0];
      u_we          = 1'b0;
      u_waddr       = slot_free;
      u_wdata       = {cur_start_ff, LW'(g_ff)};
      u_raddr       = idx_ff[IW-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            f_we     = 1'b1;
            f_waddr  = '0;
            f_wdata  = {SW'(0), LW'(PG)};
            count_in = CW'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               zero_in      = req_size == '0;
               div_start    = 1'b1;
               div_dividend = (req_func == ffpa_pkg::FUNC_FREE) ?
                              QW'(req_free_addr) : req_size;
               grant_in     = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               g_in   = div_quo;
               idx_in = '0;
               if (func_ff == ffpa_pkg::FUNC_ALLOC) begin
                  if (div_rem != '0 || zero_ff) begin
                     status_in = ffpa_pkg::ST_BAD_SIZE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_ARD;
                  end
               end else begin
                  if (div_rem != '0) begin
                     status_in = ffpa_pkg::ST_NOT_ALLOC;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_URD;
                  end
               end
            end
         end
         S_ARD: begin
            if (idx_ff == count_ff) begin
               status_in = ffpa_pkg::ST_NO_SPACE;
               state_in  = S_RESP;
            end else begin
               state_in = S_ACHK;
            end
         end
         S_ACHK: begin
            if (XW'(rd_len) >= XW'(g_ff)) begin
               cur_start_in = rd_start;
               cur_len_in   = rd_len;
               if (!slot_found) begin
                  status_in = ffpa_pkg::ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_AGRANT;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_ARD;
            end
         end
         S_AGRANT: begin
            u_we                     = 1'b1;
            used_valid_in[slot_free] = 1'b1;
            grant_in  = ffpa_pkg::ADDR_W'(XW'(cur_start_ff) * XW'(GRANULE_BYTES));
            status_in = ffpa_pkg::ST_OK;
            if (XW'(cur_len_ff) == XW'(g_ff)) begin
               state_in = S_RMRD;
            end else begin
               f_we     = 1'b1;
               f_wdata  = {SW'(XW'(cur_start_ff) + XW'(g_ff)),
                           LW'(XW'(cur_len_ff) - XW'(g_ff))};
               state_in = S_RESP;
            end
         end
         S_RMRD: begin
            f_raddr = IW'(idx_ff + CW'(1));
            if (idx_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_RMWR;
            end
         end
         S_RMWR: begin
            f_we     = 1'b1;
            idx_in   = idx_ff + CW'(1);
            state_in = S_RMRD;
         end
         S_URD: begin
            if (idx_ff == CW'(MAX_ENTRIES)) begin
               status_in = ffpa_pkg::ST_NOT_ALLOC;
               state_in  = S_RESP;
            end else if (!used_valid_ff[idx_ff[IW-1:0]]) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               state_in = S_UCHK;
            end
         end
         S_UCHK: begin
            if (XW'(ud_start) == XW'(g_ff)) begin
               slot_in  = idx_ff[IW-1:0];
               ulen_in  = ud_len;
               idx_in   = '0;
               state_in = S_PRD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_URD;
            end
         end
         S_PRD: begin
            if (idx_ff == count_ff) begin
               state_in = S_FDEC;
            end else begin
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (XW'(rd_start) < XW'(g_ff)) begin
               prev_start_in = rd_start;
               prev_len_in   = rd_len;
               idx_in        = idx_ff + CW'(1);
               state_in      = S_PRD;
            end else begin
               cur_start_in = rd_start;
               cur_len_in   = rd_len;
               state_in     = S_FDEC;
            end
         end
         S_FDEC: begin
            if (!join_l && !join_r && count_ff == CW'(MAX_ENTRIES)) begin
               status_in = ffpa_pkg::ST_FULL;
               state_in  = S_RESP;
            end else begin
               used_valid_in[slot_ff] = 1'b0;
               status_in              = ffpa_pkg::ST_OK;
               if (join_l && join_r) begin
                  f_we     = 1'b1;
                  f_waddr  = IW'(idx_ff - CW'(1));
                  f_wdata  = {prev_start_ff, LW'(XW'(prev_len_ff) + XW'(ulen_ff) +
                                                 XW'(cur_len_ff))};
                  state_in = S_RMRD;
               end else if (join_l) begin
                  f_we     = 1'b1;
                  f_waddr  = IW'(idx_ff - CW'(1));
                  f_wdata  = {prev_start_ff, LW'(XW'(prev_len_ff) + XW'(ulen_ff))};
                  state_in = S_RESP;
               end else if (join_r) begin
                  f_we     = 1'b1;
                  f_wdata  = {s_gran, LW'(XW'(cur_len_ff) + XW'(ulen_ff))};
                  state_in = S_RESP;
               end else begin
                  pos_in   = idx_ff;
                  idx_in   = count_ff;
                  state_in = S_INSRD;
               end
            end
         end
         S_INSRD: begin
            f_raddr = IW'(idx_ff - CW'(1));
            if (idx_ff == pos_ff) begin
               state_in = S_INSPUT;
            end else begin
               state_in = S_INSWR;
            end
         end
         S_INSWR: begin
            f_we     = 1'b1;
            idx_in   = idx_ff - CW'(1);
            state_in = S_INSRD;
         end
         S_INSPUT: begin
            f_we     = 1'b1;
            f_waddr  = pos_ff[IW-1:0];
            f_wdata  = {s_gran, ulen_ff};
            count_in = count_ff + CW'(1);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_grant_in  = (status_ff == ffpa_pkg::ST_OK) ? grant_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         count_ff      <= '0;
         used_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         used_valid_ff <= used_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff       <= func_in;
      zero_ff       <= zero_in;
      g_ff          <= g_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      cur_start_ff  <= cur_start_in;
      cur_len_ff    <= cur_len_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      ulen_ff       <= ulen_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   assign req_stall      = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_grant_addr = rsp_grant_ff;

`include "first_fit_page_allocator_macros.svh"

   `FFPA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_ENTRIES), "free count beyond table depth")
   `FFPA_ASSERT_NOW(a_grant_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ffpa_pkg::ST_OK, rsp_grant_ff == '0, "grant address on refused item")
   `FFPA_ASSERT_NEXT(a_rsp_from_resp, clock, reset, !rsp_valid_ff && state_ff != S_RESP, !rsp_valid_ff, "result raised outside result state")

endmodule

`default_nettype wire

[src/ffpa_ram.sv]
// Simple dual-port synchronous memory, one write and one registered read port.
// Depends on nothing; holds the free and allocated tables.
`default_nettype none

module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[src/ffpa_div.sv]
// Divider by the granule size through reciprocal multiplication.
// Depends on ffpa_pkg for the request width.
`default_nettype none

module ffpa_div #(
   parameter int DIVISOR = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [ffpa_pkg::REQ_W-1:0]       dividend,
   output logic                                  done,
   output logic      [ffpa_pkg::REQ_W-1:0]       quo,
   output logic      [$clog2(DIVISOR+1)-1:0]     rem
);

   localparam int     QW = ffpa_pkg::REQ_W;
   localparam int     RW = $clog2(DIVISOR + 1);
   localparam int     DW = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
   localparam int     K  = QW + DW;
   localparam longint M  = ((longint'(1) << K) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
   localparam int     MW = K + 1;
   localparam int     PW = QW + MW;

   logic               stage_ff, stage_in;
   logic               done_ff, done_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [QW-1:0]      x_ff, x_in;
   logic [RW-1:0]      r_ff, r_in;
   logic [PW-1:0]      prod;
   logic [QW-1:0]      back;

   always_comb begin
      prod     = PW'(dividend) * PW'(M);
      back     = QW'(q_ff * QW'(DIVISOR));
      stage_in = start;
      done_in  = stage_ff;
      q_in     = q_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      if (start) begin
         q_in = QW'(prod >> K);
         x_in = dividend;
      end
      if (stage_ff) begin
         r_in = RW'(x_ff - back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      q_ff <= q_in;
      x_ff <= x_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;

endmodule

`default_nettype wire
